[hdl/ipv4_trie_route_forwarder_core_macros.svh]
// Assertion helpers used by the checker file.
`ifndef IPV4_TRIE_ROUTE_FORWARDER_CORE_MACROS_SVH
`define IPV4_TRIE_ROUTE_FORWARDER_CORE_MACROS_SVH

// concurrent assertion on a named clock, disabled during reset
`define ITRF_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same, on the usual clock and reset names
`define ITRF_ASSERT(label, prop, msg) \
   `ITRF_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

[hdl/itrf_pkg.sv]
package itrf_pkg;

   localparam int ADDR_BITS          = 32;
   localparam int BIT_IDX_W          = 5;
   localparam int LEVEL_W            = 6;
   localparam int PLEN_W             = 6;
   localparam int TTL_W              = 8;
   localparam int STATUS_W           = 3;
   localparam int DEFAULT_NODE_COUNT = 1024;

   localparam logic CMD_ADD     = 1'b0;
   localparam logic CMD_FORWARD = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_FORWARD   = 3'd0,
      ST_LOCAL     = 3'd1,
      ST_TTL_ERROR = 3'd2,
      ST_NO_ROUTE  = 3'd3,
      ST_ADDED     = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_STEP,
      S_DONE
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic       take;        // input ready
      logic       advance;     // descend to existing child
      logic       alloc;       // allocate child, write current node
      logic       write_end;   // mark current node as route end
      logic       write_back;  // write current node unchanged
      logic       track;       // remember route end seen by forward walk
      logic       finish;      // latch result code
      status_type code;
      logic       emit;        // load output register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_valid;
      logic is_add;
      logic ttl_zero;
      logic is_local;
      logic level_done;
      logic present;
      logic full;
      logic found;
      logic out_free;
   } dp_status_type;

endpackage

[hdl/itrf_req_if.sv]
interface itrf_req_if import itrf_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [ADDR_BITS-1:0] address;
   logic [PLEN_W-1:0]    prefix_length;
   logic [ADDR_BITS-1:0] route_next_hop;
   logic [TTL_W-1:0]     time_to_live;

   modport source (output valid, cmd, address, prefix_length, route_next_hop,
                   time_to_live, input ready);
   modport sink   (input valid, cmd, address, prefix_length, route_next_hop,
                   time_to_live, output ready);
endinterface

[hdl/itrf_rsp_if.sv]
interface itrf_rsp_if import itrf_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [ADDR_BITS-1:0] next_hop;
   logic [TTL_W-1:0]     new_ttl;

   modport source (output valid, status, next_hop, new_ttl, input ready);
   modport sink   (input valid, status, next_hop, new_ttl, output ready);
endinterface

[hdl/itrf_ctrl.sv]
module itrf_ctrl import itrf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = ST_FORWARD;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (stat.req_valid) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            priority if (stat.is_add) begin
               priority if (stat.level_done) begin
                  cmd.write_end = 1'b1;
                  cmd.finish    = 1'b1;
                  cmd.code      = ST_ADDED;
                  state_in      = S_DONE;
               end else if (stat.present) begin
                  cmd.advance = 1'b1;
               end else if (stat.full) begin
                  // keep a fresh node's empty flags in memory
                  cmd.write_back = 1'b1;
                  cmd.finish     = 1'b1;
                  cmd.code       = ST_FULL;
                  state_in       = S_DONE;
               end else begin
                  cmd.alloc = 1'b1;
               end
            end else if (stat.ttl_zero) begin
               cmd.finish = 1'b1;
               cmd.code   = ST_TTL_ERROR;
               state_in   = S_DONE;
            end else if (stat.is_local) begin
               cmd.finish = 1'b1;
               cmd.code   = ST_LOCAL;
               state_in   = S_DONE;
            end else begin
               cmd.track = 1'b1;
               if (stat.level_done || !stat.present) begin
                  cmd.finish = 1'b1;
                  cmd.code   = stat.found ? ST_FORWARD : ST_NO_ROUTE;
                  state_in   = S_DONE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hdl/itrf_datapath.sv]
module itrf_datapath import itrf_pkg::*; #(
   parameter int NODE_COUNT = DEFAULT_NODE_COUNT
) (
   input  logic                 clock,
   input  logic                 reset,
   itrf_req_if.sink             req_ch,
   itrf_rsp_if.source           rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [ADDR_BITS-1:0] csr_write_data,
   input  dp_cmd_type           cmd,
   output dp_status_type        stat
);

   localparam int IDX_W = $clog2(NODE_COUNT);
   localparam int CNT_W = $clog2(NODE_COUNT + 1);

   typedef struct packed {
      logic [IDX_W-1:0]     child_zero;
      logic [IDX_W-1:0]     child_one;
      logic                 has_zero;
      logic                 has_one;
      logic                 route_end;
      logic [ADDR_BITS-1:0] hop;
   } node_word_type;

   // node memory
   node_word_type node_mem [NODE_COUNT];
   node_word_type rd_word_ff;

   // item registers
   logic                 cmd_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ADDR_BITS-1:0] hop_ff;
   logic [TTL_W-1:0]     ttl_ff;
   logic [LEVEL_W-1:0]   limit_ff;
   logic [LEVEL_W-1:0]   level_ff;
   logic [IDX_W-1:0]     node_ff;
   logic                 alloc_ff;
   logic                 found_ff;
   logic [ADDR_BITS-1:0] best_ff;
   status_type           code_ff;

   // trie control state
   logic [CNT_W-1:0]     nodes_used_ff;
   logic                 root_has_zero_ff;
   logic                 root_has_one_ff;
   logic                 root_end_ff;
   logic [ADDR_BITS-1:0] local_ff;

   // output register
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [ADDR_BITS-1:0] rsp_next_hop_ff;
   logic [TTL_W-1:0]     rsp_ttl_ff;

   node_word_type        cur_word;
   node_word_type        wr_word;
   logic [BIT_IDX_W-1:0] bit_idx;
   logic                 addr_bit;
   logic                 present;
   logic [IDX_W-1:0]     child;
   logic [IDX_W-1:0]     new_idx;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic                 load;
   logic [PLEN_W-1:0]    plen_sat;

   assign load = cmd.take && req_ch.valid;

   // current node: root flags live in flops, a fresh node is empty
   always_comb begin
      cur_word = rd_word_ff;
      if (node_ff == '0) begin
         cur_word.has_zero  = root_has_zero_ff;
         cur_word.has_one   = root_has_one_ff;
         cur_word.route_end = root_end_ff;
      end
      if (alloc_ff) begin
         cur_word = '0;
      end
   end

   // branch along the address bit of this level
   assign bit_idx  = BIT_IDX_W'(ADDR_BITS - 1) - level_ff[BIT_IDX_W-1:0];
   assign addr_bit = addr_ff[bit_idx];
   assign present  = addr_bit ? cur_word.has_one : cur_word.has_zero;
   assign child    = addr_bit ? cur_word.child_one : cur_word.child_zero;
   assign new_idx  = nodes_used_ff[IDX_W-1:0];
   assign rd_addr  = cmd.advance ? child : '0;

   // modified node word
   always_comb begin
      wr_word = cur_word;
      if (cmd.alloc) begin
         if (addr_bit) begin
            wr_word.child_one = new_idx;
            wr_word.has_one   = 1'b1;
         end else begin
            wr_word.child_zero = new_idx;
            wr_word.has_zero   = 1'b1;
         end
      end
      if (cmd.write_end) begin
         wr_word.route_end = 1'b1;
         wr_word.hop       = hop_ff;
      end
   end

   assign wr_en = cmd.alloc || cmd.write_end || cmd.write_back;

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[node_ff] <= wr_word;
      end
      rd_word_ff <= node_mem[rd_addr];
   end

   // saturated prefix length
   assign plen_sat = (req_ch.prefix_length > PLEN_W'(ADDR_BITS)) ?
                     PLEN_W'(ADDR_BITS) : req_ch.prefix_length;

   // item capture and walk position
   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff   <= req_ch.cmd;
         addr_ff  <= req_ch.address;
         hop_ff   <= req_ch.route_next_hop;
         ttl_ff   <= req_ch.time_to_live;
         limit_ff <= (req_ch.cmd == CMD_ADD) ? LEVEL_W'(plen_sat) : LEVEL_W'(ADDR_BITS);
         level_ff <= '0;
         node_ff  <= '0;
         alloc_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.advance) begin
            node_ff  <= child;
            level_ff <= level_ff + LEVEL_W'(1);
         end
         if (cmd.alloc) begin
            node_ff  <= new_idx;
            level_ff <= level_ff + LEVEL_W'(1);
            alloc_ff <= 1'b1;
         end
         if (cmd.track && cur_word.route_end) begin
            found_ff <= 1'b1;
            best_ff  <= cur_word.hop;
         end
      end
      if (cmd.finish) begin
         code_ff <= cmd.code;
      end
   end

   // node count, root flags, local address
   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_used_ff    <= CNT_W'(1);
         root_has_zero_ff <= 1'b0;
         root_has_one_ff  <= 1'b0;
         root_end_ff      <= 1'b0;
         local_ff         <= '0;
      end else begin
         if (cmd.alloc) begin
            nodes_used_ff <= nodes_used_ff + CNT_W'(1);
         end
         if (wr_en && node_ff == '0) begin
            root_has_zero_ff <= wr_word.has_zero;
            root_has_one_ff  <= wr_word.has_one;
            root_end_ff      <= wr_word.route_end;
         end
         if (csr_write_enable) begin
            local_ff <= csr_write_data;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff   <= code_ff;
         rsp_next_hop_ff <= (code_ff == ST_FORWARD) ? best_ff : '0;
         rsp_ttl_ff      <= (code_ff == ST_FORWARD) ? ttl_ff - TTL_W'(1) : '0;
      end
   end

   assign req_ch.ready    = cmd.take;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.next_hop = rsp_next_hop_ff;
   assign rsp_ch.new_ttl  = rsp_ttl_ff;

   // status to controller
   assign stat.req_valid  = req_ch.valid;
   assign stat.is_add     = (cmd_ff == CMD_ADD);
   assign stat.ttl_zero   = (ttl_ff == '0);
   assign stat.is_local   = (addr_ff == local_ff);
   assign stat.level_done = (level_ff == limit_ff);
   assign stat.present    = present;
   assign stat.full       = (nodes_used_ff >= CNT_W'(NODE_COUNT));
   assign stat.found      = found_ff || cur_word.route_end;
   assign stat.out_free   = !rsp_valid_ff || rsp_ch.ready;

endmodule

[hdl/ipv4_trie_route_forwarder_core.sv]
// IPv4 longest-prefix-match router over a binary trie in a node memory.
// req_ch carries one word per command: cmd 0 adds a route (address,
// prefix_length, route_next_hop), cmd 1 forwards a header (address,
// time_to_live). rsp_ch returns exactly one word per command: status,
// next_hop and new_ttl. csr_write_enable/csr_write_data set the local address.
// Timing: the trie walk reads one node per cycle from the node memory
// (registered read), descending one level per node; TTL error and local
// delivery finish at the first walk step without descending. After the last
// walk step the result code is latched, then loaded into the output register
// as soon as that register is free.
// One item is in work at a time; the next is accepted while the previous
// result still waits in the output register.
// Reset (synchronous) empties the trie at once: root flags and local address
// are cleared, the node count returns to one; no clearing pass runs on memory.
// When the receiver stalls, a finished item waits until the output register
// frees, and no new item is taken meanwhile.
module ipv4_trie_route_forwarder_core import itrf_pkg::*; #(
   parameter int NODE_COUNT = DEFAULT_NODE_COUNT
) (
   input  logic                 clock,
   input  logic                 reset,
   itrf_req_if.sink             req_ch,
   itrf_rsp_if.source           rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [ADDR_BITS-1:0] csr_write_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_stat;

   // sequencer
   itrf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (dp_stat),
      .cmd   (dp_cmd)
   );

   // trie memory and walk datapath
   itrf_datapath #(
      .NODE_COUNT (NODE_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (dp_cmd),
      .stat             (dp_stat)
   );

endmodule

[hdl/itrf_checker.sv]
`include "ipv4_trie_route_forwarder_core_macros.svh"

module itrf_checker import itrf_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [ADDR_BITS-1:0] rsp_next_hop,
   input logic [TTL_W-1:0]     rsp_new_ttl
);

   // a pending result stays until taken
   `ITRF_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped while stalled")

   // stalled result word does not change
   `ITRF_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_next_hop) && $stable(rsp_new_ttl), "rsp word changed while stalled")

   // one item at a time: input closes right after an accept
   `ITRF_ASSERT(a_busy_after_take, req_valid && req_ready |=> !req_ready, "input ready while item in work")

   // no result can be raised in the cycle right after an accept
   `ITRF_ASSERT(a_no_early_rsp, req_valid && req_ready |=> !$rose(rsp_valid), "result too early after accept")

   // only forwarded packets carry a next hop and TTL
   `ITRF_ASSERT(a_zero_fields, rsp_valid && rsp_status != ST_FORWARD |-> rsp_next_hop == '0 && rsp_new_ttl == '0, "non-forward result with payload")

endmodule

bind ipv4_trie_route_forwarder_core itrf_checker u_itrf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_status   (rsp_ch.status),
   .rsp_next_hop (rsp_ch.next_hop),
   .rsp_new_ttl  (rsp_ch.new_ttl)
);

[tb/tb_ipv4_trie_route_forwarder_core.sv]
module tb_ipv4_trie_route_forwarder_core import itrf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 20;
   localparam int TRIE_NODES     = DEFAULT_NODE_COUNT;
   localparam int PHASES         = 4;
   localparam int PHASE_WORDS    = 150;
   localparam int DIRECTED_ROWS  = 25;
   localparam int HOLD_AT        = 250;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int REPORT_LIMIT   = 10;

   // one command word as offered on the request channel
   typedef struct packed {
      logic                 cmd;
      logic [ADDR_BITS-1:0] address;
      logic [PLEN_W-1:0]    prefix_length;
      logic [ADDR_BITS-1:0] route_next_hop;
      logic [TTL_W-1:0]     time_to_live;
   } route_cmd_type;

   typedef struct packed {
      status_type           status;
      logic [ADDR_BITS-1:0] next_hop;
      logic [TTL_W-1:0]     new_ttl;
   } route_result_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] address;
      logic [PLEN_W-1:0]    prefix_length;
   } prefix_entry_type;

   // directed row: command plus a typed result where it is obvious
   typedef struct packed {
      route_cmd_type    word;
      logic             check_fixed;
      route_result_type fixed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [ADDR_BITS-1:0] csr_write_data;

   itrf_req_if req_bus ();
   itrf_rsp_if rsp_bus ();

   ipv4_trie_route_forwarder_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // shadow trie
   int                   trie_zero      [TRIE_NODES];
   int                   trie_one       [TRIE_NODES];
   bit                   trie_has_zero  [TRIE_NODES];
   bit                   trie_has_one   [TRIE_NODES];
   bit                   trie_route_end [TRIE_NODES];
   logic [ADDR_BITS-1:0] trie_hop       [TRIE_NODES];
   int                   trie_nodes_used = 1;
   logic [ADDR_BITS-1:0] local_addr_shadow = '0;

   route_result_type pending_results [$];
   prefix_entry_type known_prefixes [$];
   logic [ADDR_BITS-1:0] net_pool [6];

   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  words_checked = 0;
   int  status_seen [6];
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  steady_run = 1'b0;
   route_result_type want;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // empty trie, ttl check ahead of local check, local address still zero
      '{'{CMD_FORWARD, 32'h01020304, 6'd0, 32'h0, 8'd5}, 1'b1, '{ST_NO_ROUTE, 32'h0, 8'd0}},
      '{'{CMD_FORWARD, 32'h01020304, 6'd63, 32'h0, 8'd0}, 1'b1, '{ST_TTL_ERROR, 32'h0, 8'd0}},
      '{'{CMD_FORWARD, 32'h00000000, 6'd0, 32'hFFFFFFFF, 8'd9}, 1'b1, '{ST_LOCAL, 32'h0, 8'd0}},
      '{'{CMD_FORWARD, 32'h00000000, 6'd0, 32'h0, 8'd0}, 1'b1, '{ST_TTL_ERROR, 32'h0, 8'd0}},
      // full-length host route, then a walk that falls off one bit short
      '{'{CMD_ADD, 32'hFFFFFFFF, 6'd32, 32'h11111111, 8'd0}, 1'b1, '{ST_ADDED, 32'h0, 8'd0}},
      '{'{CMD_FORWARD, 32'hFFFFFFFE, 6'd0, 32'h0, 8'd255}, 1'b1, '{ST_NO_ROUTE, 32'h0, 8'd0}},
      '{'{CMD_FORWARD, 32'hFFFFFFFF, 6'd0, 32'h0, 8'd1}, 1'b1,
        '{ST_FORWARD, 32'h11111111, 8'd0}},
      // nested prefixes and an overwrite of an equal prefix
      '{'{CMD_ADD, 32'hC0A80000, 6'd16, 32'h0A000001, 8'd0}, 1'b1, '{ST_ADDED, 32'h0, 8'd0}},
      '{'{CMD_ADD, 32'hC0A80100, 6'd24, 32'h0A000002, 8'd0}, 1'b1, '{ST_ADDED, 32'h0, 8'd0}},
      '{'{CMD_FORWARD, 32'hC0A80105, 6'd0, 32'h0, 8'd64}, 1'b0, '0},
      '{'{CMD_FORWARD, 32'hC0A8FF05, 6'd0, 32'h0, 8'd64}, 1'b0, '0},
      '{'{CMD_ADD, 32'hC0A80000, 6'd16, 32'hFFFFFFFF, 8'd0}, 1'b0, '0},
      '{'{CMD_FORWARD, 32'hC0A80203, 6'd0, 32'h0, 8'd255}, 1'b0, '0},
      // prefix length beyond 32 saturates
      '{'{CMD_ADD, 32'h0A0B0C0D, 6'd63, 32'h00000022, 8'd255}, 1'b0, '0},
      '{'{CMD_ADD, 32'h0A0B0C0E, 6'd33, 32'h00000033, 8'd0}, 1'b0, '0},
      '{'{CMD_FORWARD, 32'h0A0B0C0D, 6'd0, 32'h0, 8'd2}, 1'b0, '0},
      '{'{CMD_FORWARD, 32'h0A0B0C0F, 6'd0, 32'h0, 8'd128}, 1'b0, '0},
      // default route on the root
      '{'{CMD_ADD, 32'h00000000, 6'd0, 32'hDEADBEEF, 8'd0}, 1'b1, '{ST_ADDED, 32'h0, 8'd0}},
      '{'{CMD_FORWARD, 32'h0A0B0C0F, 6'd0, 32'h0, 8'd128}, 1'b0, '0},
      '{'{CMD_FORWARD, 32'h7FFFFFFF, 6'd0, 32'h0, 8'd3}, 1'b0, '0},
      '{'{CMD_ADD, 32'h80000000, 6'd1, 32'h00000000, 8'd0}, 1'b0, '0},
      '{'{CMD_FORWARD, 32'h80000001, 6'd0, 32'h0, 8'd200}, 1'b0, '0},
      '{'{CMD_ADD, 32'h00000000, 6'd32, 32'hA5A5A5A5, 8'd0}, 1'b0, '0},
      '{'{CMD_FORWARD, 32'h00000000, 6'd0, 32'h0, 8'd10}, 1'b1, '{ST_LOCAL, 32'h0, 8'd0}},
      '{'{CMD_FORWARD, 32'h00000001, 6'd0, 32'h0, 8'd10}, 1'b0, '0}
   };

   // insert into or walk the shadow trie, giving the word the block must return
   function automatic route_result_type predict_route_result(route_cmd_type word);
      route_result_type res;
      int            node;
      int            next;
      int            plen;
      int            lvl;
      logic          b;
      bit            present;
      bit            found;
      bit            walking;
      res = '{ST_ADDED, '0, '0};
      node = 0;
      if (word.cmd == CMD_ADD) begin
         plen = (word.prefix_length > ADDR_BITS) ? ADDR_BITS : int'(word.prefix_length);
         for (lvl = 0; lvl < plen && res.status == ST_ADDED; lvl++) begin
            b = word.address[ADDR_BITS-1-lvl];
            present = b ? trie_has_one[node] : trie_has_zero[node];
            if (present) begin
               node = b ? trie_one[node] : trie_zero[node];
            end else if (trie_nodes_used >= TRIE_NODES) begin
               res.status = ST_FULL;
            end else begin
               next = trie_nodes_used;
               trie_nodes_used++;
               trie_has_zero[next] = 1'b0;
               trie_has_one[next] = 1'b0;
               trie_route_end[next] = 1'b0;
               if (b) begin
                  trie_one[node] = next;
                  trie_has_one[node] = 1'b1;
               end else begin
                  trie_zero[node] = next;
                  trie_has_zero[node] = 1'b1;
               end
               node = next;
            end
         end
         if (res.status == ST_ADDED) begin
            trie_route_end[node] = 1'b1;
            trie_hop[node] = word.route_next_hop;
         end
      end else if (word.time_to_live == 0) begin
         res.status = ST_TTL_ERROR;
      end else if (word.address == local_addr_shadow) begin
         res.status = ST_LOCAL;
      end else begin
         // deepest route end along the destination bits wins
         found = 1'b0;
         walking = 1'b1;
         for (lvl = 0; lvl <= ADDR_BITS && walking; lvl++) begin
            if (trie_route_end[node]) begin
               found = 1'b1;
               res.next_hop = trie_hop[node];
            end
            if (lvl == ADDR_BITS) begin
               walking = 1'b0;
            end else begin
               b = word.address[ADDR_BITS-1-lvl];
               present = b ? trie_has_one[node] : trie_has_zero[node];
               if (present) node = b ? trie_one[node] : trie_zero[node];
               else walking = 1'b0;
            end
         end
         if (found) begin
            res.status = ST_FORWARD;
            res.new_ttl = word.time_to_live - 8'd1;
         end else begin
            res.status = ST_NO_ROUTE;
         end
      end
      return res;
   endfunction

   // offer one word, with random gaps outside the steady run; predict at acceptance
   task automatic send_command(input route_cmd_type word, input bit use_fixed,
                               input route_result_type fixed);
      route_result_type predicted;
      while (!steady_run && $urandom_range(99) < 25) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.cmd            <= word.cmd;
      req_bus.address        <= word.address;
      req_bus.prefix_length  <= word.prefix_length;
      req_bus.route_next_hop <= word.route_next_hop;
      req_bus.time_to_live   <= word.time_to_live;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_route_result(word);
      pending_results.push_back(use_fixed ? fixed : predicted);
      if (word.cmd == CMD_ADD)
         known_prefixes.push_back('{word.address, word.prefix_length});
   endtask

   // result side: check each word, random stalls outside the steady run, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            words_checked++;
            if (rsp_bus.status < 6) status_seen[rsp_bus.status]++;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result word %0d arrived with nothing expected: status %0d",
                           words_checked, rsp_bus.status);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.status !== want.status || rsp_bus.next_hop !== want.next_hop ||
                   rsp_bus.new_ttl !== want.new_ttl) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"result word %0d: expected status %0d hop %h ttl %0d, ",
                               "got status %0d hop %h ttl %0d"}, words_checked,
                              want.status, want.next_hop, want.new_ttl,
                              rsp_bus.status, rsp_bus.next_hop, rsp_bus.new_ttl);
               end
            end
         end
         if (!hold_done && words_checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady_run || ($urandom_range(99) >= 25);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ipv4_trie_route_forwarder_core: mismatch");
      $finish;
   end

   initial begin
      route_cmd_type        word;
      prefix_entry_type     pick;
      logic [ADDR_BITS-1:0] mask;
      logic [ADDR_BITS-1:0] local_value;
      int                   pct;
      int                   keep;
      int                   phase;
      int                   n;
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_write_data         = '0;
      req_bus.valid          = 1'b0;
      req_bus.cmd            = CMD_ADD;
      req_bus.address        = '0;
      req_bus.prefix_length  = '0;
      req_bus.route_next_hop = '0;
      req_bus.time_to_live   = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (net_pool[i]) net_pool[i] = $urandom();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, local address still at its reset value
      foreach (directed_rows[i])
         send_command(directed_rows[i].word, directed_rows[i].check_fixed,
                      directed_rows[i].fixed);
      req_bus.valid <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         // drain, then move the local address
         while (pending_results.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
         unique case (phase)
            0:       local_value = 32'hFFFFFFFF;
            1:       local_value = $urandom();
            2:       local_value = 32'h00000000;
            default: begin
               pick = known_prefixes[$urandom_range(known_prefixes.size() - 1)];
               local_value = pick.address;
            end
         endcase
         csr_write_enable <= 1'b1;
         csr_write_data   <= local_value;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         local_addr_shadow = local_value;
         steady_run = (phase == 2);

         for (n = 0; n < PHASE_WORDS; n++) begin
            word.route_next_hop = $urandom();
            word.time_to_live   = TTL_W'($urandom());
            word.prefix_length  = PLEN_W'($urandom());
            if ($urandom_range(99) < 35) begin
               // add: mostly prefixes around a few networks so paths share nodes
               word.cmd = CMD_ADD;
               pct = $urandom_range(99);
               if (pct < 20) begin
                  pick = known_prefixes[$urandom_range(known_prefixes.size() - 1)];
                  word.address       = pick.address;
                  word.prefix_length = pick.prefix_length;
               end else begin
                  keep = $urandom_range(32);
                  mask = (keep == 0) ? '0 : ~32'h0 << (ADDR_BITS - keep);
                  word.address = (net_pool[$urandom_range(5)] & mask) | ($urandom() & ~mask);
                  pct = $urandom_range(99);
                  if (pct < 2) word.prefix_length = '0;
                  else if (pct < 12) word.prefix_length = PLEN_W'($urandom_range(7, 1));
                  else if (pct < 55) word.prefix_length = PLEN_W'($urandom_range(24, 8));
                  else if (pct < 85) word.prefix_length = PLEN_W'($urandom_range(32, 25));
                  else if (pct < 95) word.prefix_length = PLEN_W'($urandom_range(63, 33));
                  else begin
                     word.address       = $urandom();
                     word.prefix_length = PLEN_W'(ADDR_BITS);
                  end
               end
            end else begin
               // forward: mostly inside known prefixes, some local and stray
               word.cmd = CMD_FORWARD;
               pct = $urandom_range(99);
               pick = known_prefixes[$urandom_range(known_prefixes.size() - 1)];
               keep = (pick.prefix_length > ADDR_BITS) ? ADDR_BITS : int'(pick.prefix_length);
               mask = (keep == 0) ? '0 : ~32'h0 << (ADDR_BITS - keep);
               if (pct < 6) word.address = local_addr_shadow;
               else if (pct < 20) word.address = pick.address;
               else if (pct < 75) word.address = (pick.address & mask) | ($urandom() & ~mask);
               else word.address = $urandom();
               pct = $urandom_range(99);
               if (pct < 4) word.time_to_live = '0;
               else if (pct < 14) word.time_to_live = TTL_W'(1);
               else if (pct < 19) word.time_to_live = TTL_W'(255);
               else word.time_to_live = TTL_W'($urandom_range(254, 1));
            end
            send_command(word, 1'b0, '0);
         end
         req_bus.valid <= 1'b0;
      end
      steady_run = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatch_count += pending_results.size();

      $display("%0d words checked: %0d forwarded, %0d local, %0d ttl error, %0d no route",
               words_checked, status_seen[ST_FORWARD], status_seen[ST_LOCAL],
               status_seen[ST_TTL_ERROR], status_seen[ST_NO_ROUTE]);
      $display("%0d routes added, %0d rejected as table full, %0d of %0d trie nodes used",
               status_seen[ST_ADDED], status_seen[ST_FULL], trie_nodes_used, TRIE_NODES);
      if (mismatch_count == 0) begin
         $display("ipv4_trie_route_forwarder_core: match");
      end else begin
         $display("ipv4_trie_route_forwarder_core: mismatch");
      end
      $finish;
   end

endmodule
